/* hdl/rps_pkg.sv */
// rps_pkg: shared widths and constants for the permutation shuffle block.
// No dependencies; imported by random_permutation_shuffle.
package rps_pkg;

    // Field widths
    localparam int unsigned RV_W   = 15;    // raw random draw
    localparam int unsigned V_W    = 14;    // draw reduced below the modulus
    localparam int unsigned PL_W   = 11;    // perm_length register
    localparam int unsigned ELEM_W = 10;    // emitted element
    localparam int unsigned R_W    = 15;    // division remainder, below twice the modulus

    // Draw modulus and its scaled reciprocal (floor(2^32 / 10000))
    localparam int unsigned DRAW_MODULUS = 10000;
    localparam int unsigned RECIP_W      = 19;
    localparam int unsigned RECIP        = 429496;
    localparam int unsigned RECIP_SHIFT  = 32;

    // Reset and default values
    localparam int unsigned PERM_LENGTH_RESET  = 1024;
    localparam int unsigned DEFAULT_MAX_LENGTH = 1024;

endpackage

/* hdl/random_permutation_shuffle.sv */
// random_permutation_shuffle: forward Fisher-Yates shuffle, one element per draw.
// Depends on rps_pkg.
//
// Input channel (in_valid/in_ready, random_value) takes one raw draw per
// transaction; output channel (out_valid/out_ready, element, last) gives the
// element settled at the current position, last marking the end of a run.
// cfg_wr_en/cfg_wr_data write perm_length; the user must do so only while
// idle, as the block itself does not enforce it. A draw passes front stages
// A to E, the memory read and the output register. Throughput is set by the
// single write port of the permutation memory (swap write plus retire write
// per draw): no draw issues in the cycle of a swap write; arithmetic stages
// in front buffer draws while the memory side works or waits. Reset: position
// goes to 0, perm_length to 1024, and a clearing pass invalidates every memory
// entry; in_ready stays low meanwhile. A write of perm_length below MAX_LENGTH
// starts a pass over the entries beyond the new length.
// When the receiver stalls, the output register holds its transaction, the
// memory side stops issuing, and the front stages fill before in_ready drops.
module random_permutation_shuffle #(
    parameter int unsigned MAX_LENGTH = rps_pkg::DEFAULT_MAX_LENGTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [rps_pkg::PL_W-1:0]    cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rps_pkg::RV_W-1:0]    random_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rps_pkg::ELEM_W-1:0]  element,
    output logic                        last
);
    import rps_pkg::*;

    localparam int unsigned IW = $clog2(MAX_LENGTH);        // index width
    localparam int unsigned LW = $clog2(MAX_LENGTH + 1);    // length width
    localparam int unsigned CW = (LW > PL_W) ? LW : PL_W;   // clamp compare width
    localparam int unsigned PW = V_W + LW;                  // v * remaining
    localparam int unsigned QW = PW + RECIP_W;              // reciprocal product

    // Clamp a length value to 1..MAX_LENGTH
    function automatic logic [LW-1:0] clamp_len(input logic [PL_W-1:0] x);
        logic [CW-1:0] xe;
        logic [LW-1:0] r;
        xe = CW'(x);
        if (x == '0)
            r = LW'(1);
        else if (xe > CW'(MAX_LENGTH))
            r = LW'(MAX_LENGTH);
        else
            r = LW'(x);
        return r;
    endfunction

    // Configuration and position state
    logic [PL_W-1:0] perm_length_reg;
    logic [IW-1:0]   pos_reg;
    logic [IW-1:0]   pos_next;
    logic [LW-1:0]   len_cur;
    logic [LW-1:0]   cfg_len;

    // Clearing pass
    logic            clr_busy_reg;
    logic [IW-1:0]   clr_ptr_reg;

    // Front arithmetic stages
    logic            a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg;
    logic [V_W-1:0]  a_draw_reg;
    logic [LW-1:0]   a_rem_reg;
    logic [IW-1:0]   a_pos_reg, b_pos_reg, c_pos_reg, d_pos_reg, e_pos_reg;
    logic            a_last_reg, b_last_reg, c_last_reg, d_last_reg, e_last_reg;
    logic [PW-1:0]   b_prod_reg, c_prod_reg;
    logic [LW-1:0]   c_quo_reg, d_quo_reg;
    logic [R_W-1:0]  d_rem_reg;
    logic [IW-1:0]   e_other_reg;
    logic            a_rdy, b_rdy, c_rdy, d_rdy, e_rdy;
    logic            accept;

    // Accept-side combinational values
    logic [LW-1:0]   pos_ext, pos_eff, pos_inc, rem_len;
    logic            last_cur;
    logic [V_W-1:0]  draw_mod;
    logic [QW-1:0]   recip_prod;
    logic [PW-1:0]   quo_times_mod;
    logic [PW-1:0]   rem_wide;
    logic [LW-1:0]   offset;
    logic [LW-1:0]   other_sum;

    // Memory side
    logic [IW:0]     perm_mem [MAX_LENGTH];     // {valid, value}
    logic [IW:0]     rd_a_reg, rd_b_reg;
    logic            issue;
    logic            w1_reg, w2_reg;
    logic            hit_a_reg, hit_b_reg;
    logic [IW-1:0]   m_pos_reg, m_other_reg, w2_addr_reg;
    logic            m_last_reg;
    logic [IW-1:0]   here_val, other_val;
    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    logic [IW:0]     mem_wdata;
    logic [IW+ELEM_W-1:0] elem_wide;

    // Output register
    logic                out_valid_reg;
    logic [ELEM_W-1:0]   element_reg;
    logic                last_reg;

    assign len_cur = clamp_len(perm_length_reg);
    assign cfg_len = clamp_len(cfg_wr_data);

    // Position bookkeeping at acceptance
    always_comb
    begin
        pos_ext  = LW'(pos_reg);
        pos_eff  = (pos_ext >= len_cur) ? '0 : pos_ext;
        pos_inc  = pos_eff + LW'(1);
        pos_next = (pos_inc >= len_cur) ? '0 : IW'(pos_inc);
        last_cur = (pos_eff == len_cur - LW'(1));
        rem_len  = len_cur - pos_eff;
    end

    // Draw reduced modulo 10000 (at most three subtractions)
    always_comb
    begin
        if (random_value >= RV_W'(3 * DRAW_MODULUS))
            draw_mod = V_W'(random_value - RV_W'(3 * DRAW_MODULUS));
        else if (random_value >= RV_W'(2 * DRAW_MODULUS))
            draw_mod = V_W'(random_value - RV_W'(2 * DRAW_MODULUS));
        else if (random_value >= RV_W'(DRAW_MODULUS))
            draw_mod = V_W'(random_value - RV_W'(DRAW_MODULUS));
        else
            draw_mod = V_W'(random_value);
    end

    // Division by 10000: reciprocal estimate, then one correction
    assign recip_prod    = QW'(b_prod_reg) * QW'(RECIP);
    assign quo_times_mod = PW'(c_quo_reg) * PW'(DRAW_MODULUS);
    assign rem_wide      = c_prod_reg - quo_times_mod;
    assign offset        = d_quo_reg + LW'(d_rem_reg >= R_W'(DRAW_MODULUS));
    assign other_sum     = LW'(d_pos_reg) + offset;

    // Elastic handshake through the front stages
    assign issue    = e_v_reg && !w1_reg && (!out_valid_reg || out_ready);
    assign e_rdy    = !e_v_reg || issue;
    assign d_rdy    = !d_v_reg || e_rdy;
    assign c_rdy    = !c_v_reg || d_rdy;
    assign b_rdy    = !b_v_reg || c_rdy;
    assign a_rdy    = !a_v_reg || b_rdy;
    assign in_ready = a_rdy && !clr_busy_reg;
    assign accept   = in_valid && in_ready;

    // Front stage valid bits, position and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg         <= 1'b0;
            b_v_reg         <= 1'b0;
            c_v_reg         <= 1'b0;
            d_v_reg         <= 1'b0;
            e_v_reg         <= 1'b0;
            pos_reg         <= '0;
            perm_length_reg <= PL_W'(PERM_LENGTH_RESET);
        end
        else
        begin
            if (a_rdy) a_v_reg <= accept;
            if (b_rdy) b_v_reg <= a_v_reg;
            if (c_rdy) c_v_reg <= b_v_reg;
            if (d_rdy) d_v_reg <= c_v_reg;
            if (e_rdy) e_v_reg <= d_v_reg;
            if (accept)
                pos_reg <= pos_next;
            if (cfg_wr_en)
                perm_length_reg <= cfg_wr_data;
        end
    end

    // Front stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_draw_reg <= draw_mod;
            a_rem_reg  <= rem_len;
            a_pos_reg  <= IW'(pos_eff);
            a_last_reg <= last_cur;
        end
        if (b_rdy && a_v_reg)
        begin
            b_prod_reg <= PW'(a_draw_reg) * PW'(a_rem_reg);
            b_pos_reg  <= a_pos_reg;
            b_last_reg <= a_last_reg;
        end
        if (c_rdy && b_v_reg)
        begin
            c_quo_reg  <= recip_prod[RECIP_SHIFT +: LW];
            c_prod_reg <= b_prod_reg;
            c_pos_reg  <= b_pos_reg;
            c_last_reg <= b_last_reg;
        end
        if (d_rdy && c_v_reg)
        begin
            d_quo_reg  <= c_quo_reg;
            d_rem_reg  <= rem_wide[R_W-1:0];
            d_pos_reg  <= c_pos_reg;
            d_last_reg <= c_last_reg;
        end
        if (e_rdy && d_v_reg)
        begin
            e_other_reg <= IW'(other_sum);
            e_pos_reg   <= d_pos_reg;
            e_last_reg  <= d_last_reg;
        end
    end

    // Clearing pass: after reset over all entries, after a length write
    // over the entries beyond the new length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_ptr_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_len < LW'(MAX_LENGTH))
            begin
                clr_busy_reg <= 1'b1;
                if (!clr_busy_reg || (cfg_len < LW'(clr_ptr_reg)))
                    clr_ptr_reg <= IW'(cfg_len);
            end
        end
        else if (clr_busy_reg)
        begin
            if (clr_ptr_reg == IW'(MAX_LENGTH - 1))
                clr_busy_reg <= 1'b0;
            else
                clr_ptr_reg <= clr_ptr_reg + IW'(1);
        end
    end

    // Memory side control: issue (read), W1 (swap write), W2 (retire write)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_reg <= 1'b0;
            w2_reg <= 1'b0;
        end
        else
        begin
            w1_reg <= issue;
            w2_reg <= w1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            m_pos_reg   <= e_pos_reg;
            m_other_reg <= e_other_reg;
            m_last_reg  <= e_last_reg;
            // retire write in the same cycle is not seen by the read
            hit_a_reg   <= w2_reg && (w2_addr_reg == e_pos_reg);
            hit_b_reg   <= w2_reg && (w2_addr_reg == e_other_reg);
        end
        if (w1_reg)
            w2_addr_reg <= m_pos_reg;
    end

    // Entry values; an invalid entry reads as its own index
    always_comb
    begin
        here_val  = (rd_a_reg[IW] && !hit_a_reg) ? rd_a_reg[IW-1:0] : m_pos_reg;
        other_val = (rd_b_reg[IW] && !hit_b_reg) ? rd_b_reg[IW-1:0] : m_other_reg;
        elem_wide = (IW + ELEM_W)'(other_val);
    end

    // Write port select
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_ptr_reg;
        mem_wdata = '0;
        if (w1_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = m_other_reg;
            mem_wdata = {1'b1, here_val};
        end
        else if (w2_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = w2_addr_reg;
        end
        else if (clr_busy_reg)
        begin
            mem_we = 1'b1;
        end
    end

    // Permutation memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            perm_mem[mem_waddr] <= mem_wdata;
        if (issue)
        begin
            rd_a_reg <= perm_mem[e_pos_reg];
            rd_b_reg <= perm_mem[e_other_reg];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (w1_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (w1_reg)
        begin
            element_reg <= elem_wide[ELEM_W-1:0];
            last_reg    <= m_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign element   = element_reg;
    assign last      = last_reg;

endmodule
